### rtl/core/tribonacci_prefix_sum_mod_top_assert.svh
`ifndef TRIBONACCI_PREFIX_SUM_MOD_TOP_ASSERT_SVH
`define TRIBONACCI_PREFIX_SUM_MOD_TOP_ASSERT_SVH
// Assertion helpers, clocked on clk, disabled in reset.
`define TPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TPS_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);
`endif

### rtl/core/tps_pkg.sv
`timescale 1ns / 1ps
package tps_pkg;
	localparam int INDEX_BITS = 31;
	localparam int VW = 50;
	localparam int EW = INDEX_BITS;
	localparam logic [VW-1:0] MODULUS = 50'd1000000000000007;
	typedef logic [VW-1:0] val_t;
	// 4x4 step matrix, row-major
	function automatic val_t step_mat(input logic [3:0] rc);
		case (rc)
			4'd0, 4'd2, 4'd5, 4'd6, 4'd7, 4'd9, 4'd14: step_mat = val_t'(1);
			default: step_mat = '0;
		endcase
	endfunction
	function automatic val_t start_vec(input logic [1:0] k);
		case (k)
			2'd0: start_vec = val_t'(1);
			2'd1: start_vec = val_t'(3);
			2'd2: start_vec = val_t'(2);
			default: start_vec = val_t'(1);
		endcase
	endfunction
	function automatic val_t mod_add(input val_t x, input val_t y);
		logic [VW:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, MODULUS}) s = s - {1'b0, MODULUS};
		mod_add = s[VW-1:0];
	endfunction
endpackage

### rtl/core/tps_modmul.sv
`timescale 1ns / 1ps
// Shift-and-add modular multiplier, one bit of b per cycle.
module tps_modmul
	import tps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  val_t a,
	input  val_t b,
	output logic done,
	output val_t p
);
	val_t x_q, y_q, acc_q;
	logic busy_q;
	assign p = acc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && y_q == '0) begin
				busy_q <= 1'b0;
				done <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= a;
			y_q <= b;
			acc_q <= '0;
		end else if (busy_q && y_q != '0) begin
			if (y_q[0]) acc_q <= mod_add(acc_q, x_q);
			x_q <= mod_add(x_q, x_q);
			y_q <= y_q >> 1;
		end
	end
endmodule

### rtl/core/tribonacci_prefix_sum_mod_top.sv
`timescale 1ns / 1ps
// Returns the tribonacci prefix sum S(index) mod 10^15+7. For indices 0..3,
// the sum is loaded on acceptance and ST_OUT then raises m_tvalid. Larger
// indices raise the 4x4 step matrix to index-1 by square-and-multiply, and each
// entry product goes through one shared bit-serial modular multiplier. A matrix
// product takes 64 multiplier products. The worst case is 60 matrix products
// (30 squarings, 30 multiplies). The multiplier loop sets the rate. One item at
// a time; s_tready is low while busy.
`include "tribonacci_prefix_sum_mod_top_assert.svh"
module tribonacci_prefix_sum_mod_top
	import tps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // [49:0] prefix_sum
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_BIT = 3'd1, ST_MUL = 3'd2,
		ST_WAIT = 3'd3, ST_COPY = 3'd4, ST_VEC = 3'd5, ST_VWAIT = 3'd6,
		ST_OUT = 3'd7;
	localparam logic [1:0] OP_RES = 2'd0, OP_SQR = 2'd1;

	logic [2:0] state_q;
	logic [1:0] op_q;
	logic [EW-1:0] exp_q;
	val_t res_q [16];
	val_t base_q [16];
	val_t tmp_q [16];
	val_t sum_q, out_q;
	logic [1:0] i_q, j_q, k_q;
	logic mul_start, mul_done;
	val_t mul_a, mul_b, mul_p;
	logic [EW-1:0] n_in;

	assign n_in = s_tdata[EW-1:0];
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign m_tdata = {6'd0, out_q};

	always_comb begin
		mul_a = (op_q == OP_RES) ? res_q[{i_q, k_q}] : base_q[{i_q, k_q}];
		mul_b = base_q[{k_q, j_q}];
		if (state_q == ST_VEC) begin
			mul_a = res_q[{2'd0, k_q}];
			mul_b = start_vec(k_q);
		end
	end
	assign mul_start = (state_q == ST_MUL) || (state_q == ST_VEC);

	tps_modmul u_mul (.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					state_q <= (n_in < EW'(4)) ? ST_OUT : ST_BIT;
				end
				ST_BIT: begin
					if (exp_q == '0) state_q <= ST_VEC;
					else state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_WAIT;
				ST_WAIT: if (mul_done) begin
					if (k_q == 2'd3 && i_q == 2'd3 && j_q == 2'd3) state_q <= ST_COPY;
					else if (k_q == 2'd3) state_q <= ST_MUL;
					else state_q <= ST_MUL;
				end
				ST_COPY: state_q <= ST_BIT;
				ST_VEC: state_q <= ST_VWAIT;
				ST_VWAIT: if (mul_done) begin
					state_q <= (k_q == 2'd3) ? ST_OUT : ST_VEC;
				end
				ST_OUT: if (!m_tvalid) begin
					m_tvalid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_tvalid && s_tready) begin
				exp_q <= n_in - EW'(1);
				for (int e = 0; e < 16; e++) begin
					res_q[e] <= (e % 5 == 0) ? val_t'(1) : '0;
					base_q[e] <= step_mat(4'(e));
				end
				case (n_in[1:0])
					2'd0: out_q <= '0;
					2'd1: out_q <= val_t'(1);
					2'd2: out_q <= val_t'(3);
					default: out_q <= val_t'(6);
				endcase
				sum_q <= '0;
				i_q <= '0; j_q <= '0; k_q <= '0;
			end
			ST_BIT: begin
				op_q <= exp_q[0] ? OP_RES : OP_SQR;
				i_q <= '0; j_q <= '0; k_q <= '0;
				sum_q <= '0;
			end
			ST_WAIT: if (mul_done) begin
				if (k_q == 2'd3) begin
					tmp_q[{i_q, j_q}] <= mod_add(sum_q, mul_p);
					sum_q <= '0;
					{i_q, j_q} <= {i_q, j_q} + 4'd1;
				end else begin
					sum_q <= mod_add(sum_q, mul_p);
				end
				k_q <= k_q + 2'd1;
			end
			ST_COPY: begin
				if (op_q == OP_RES) begin
					res_q <= tmp_q;
					// bit consumed; the squaring for it comes next unless no bits remain
					exp_q <= {exp_q[EW-1:1], 1'b0};
				end else begin
					base_q <= tmp_q;
					exp_q <= exp_q >> 1;
				end
			end
			ST_VWAIT: if (mul_done) begin
				sum_q <= mod_add(sum_q, mul_p);
				if (k_q == 2'd3) out_q <= mod_add(sum_q, mul_p);
				k_q <= k_q + 2'd1;
			end
			default: ;
		endcase
	end

	`TPS_ASSERT(a_out_range, !m_tvalid || out_q < MODULUS, "result not reduced")
	`TPS_ASSERT_NEXT(a_busy_ready, state_q != ST_IDLE, !s_tready || state_q == ST_IDLE,
		"ready while busy")
	`TPS_ASSERT_NEXT(a_one_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"result dropped")
endmodule

### tb/tribonacci_prefix_sum_mod_top_tb.sv
`timescale 1ns / 1ps
module tribonacci_prefix_sum_mod_top_tb;
	import tps_pkg::*;

	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam int LONG_HOLD = 40000;

	typedef val_t mat_t [4][4];

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [30:0] index
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;   // [49:0] prefix_sum

	val_t   pending_sums[$];
	int     errors = 0;
	int     sums_checked = 0;
	int     indices_sent = 0;
	int     hold_cycles = 0;
	int     hold_req = 0;
	int     hold_ack = 0;
	longint cycles = 0;

	tribonacci_prefix_sum_mod_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic val_t mulmod(input val_t a, input val_t b);
		logic [99:0] p;
		p = 100'(a) * 100'(b);
		return val_t'(p % 100'(MODULUS));
	endfunction

	function automatic val_t addmod(input val_t a, input val_t b);
		logic [50:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, MODULUS})
			s = s - {1'b0, MODULUS};
		return s[49:0];
	endfunction

	function automatic mat_t mat_product(input mat_t p, input mat_t q);
		mat_t r;
		val_t s;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				s = '0;
				for (int k = 0; k < 4; k++)
					s = addmod(s, mulmod(p[i][k], q[k][j]));
				r[i][j] = s;
			end
		return r;
	endfunction

	// S(n) by square-and-multiply of the step matrix, row 0 applied to (1,3,2,1)
	function automatic val_t tribonacci_sum(input logic [30:0] n);
		mat_t acc;
		mat_t sq;
		logic [30:0] e;
		val_t r;
		if (n == 0) return val_t'(0);
		if (n == 1) return val_t'(1);
		if (n == 2) return val_t'(3);
		if (n == 3) return val_t'(6);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				acc[i][j] = (i == j) ? val_t'(1) : val_t'(0);
				sq[i][j] = '0;
			end
		sq[0][0] = val_t'(1); sq[0][2] = val_t'(1);
		sq[1][1] = val_t'(1); sq[1][2] = val_t'(1); sq[1][3] = val_t'(1);
		sq[2][1] = val_t'(1);
		sq[3][2] = val_t'(1);
		e = n - 31'd1;
		while (e != 0) begin
			if (e[0])
				acc = mat_product(acc, sq);
			sq = mat_product(sq, sq);
			e = e >> 1;
		end
		r = '0;
		r = addmod(r, mulmod(acc[0][0], val_t'(1)));
		r = addmod(r, mulmod(acc[0][1], val_t'(3)));
		r = addmod(r, mulmod(acc[0][2], val_t'(2)));
		r = addmod(r, mulmod(acc[0][3], val_t'(1)));
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 200);
	endfunction

	task automatic send_index(input logic [30:0] idx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, idx};
		do @(posedge clk); while (!s_tready);
		pending_sums.push_back(tribonacci_sum(idx));
		indices_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
	endtask

	// receiver: random stalls, plus a forced hold-off when requested
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			m_tready <= 1'b0;
			hold_cycles <= LONG_HOLD;
			hold_ack <= hold_req;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if ($urandom_range(0, 99) < 4) begin
			m_tready <= 1'b0;
			hold_cycles <= $urandom_range(10, 150);
		end else begin
			m_tready <= ($urandom_range(0, 99) < 70);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				$display("%0t: unexpected sum %0d", $time, m_tdata[49:0]);
				errors++;
			end else begin
				if (m_tdata[49:0] !== pending_sums[0]) begin
					$display("%0t: prefix_sum expected %0d actual %0d",
						$time, pending_sums[0], m_tdata[49:0]);
					errors++;
				end
				void'(pending_sums.pop_front());
				sums_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d sums outstanding", $time, pending_sums.size());
			$display("tribonacci_prefix_sum_mod_top_tb failed");
			$finish;
		end
	end

	task automatic test_directed();
		logic [30:0] picks[$];
		picks = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd7, 31'd8,
			31'd16, 31'd31, 31'd100, 31'h7FFF_FFFF, 31'h4000_0000,
			31'h2AAA_AAAA, 31'h5555_5555};
		foreach (picks[i])
			send_index(picks[i]);
		wait_drained();
	endtask

	task automatic test_random(input int count);
		logic [30:0] idx;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			// wide indices are slow; keep them rare
			if (r < 2) idx = 31'($urandom());
			else if (r < 15) idx = 31'($urandom_range(0, 3));
			else if (r < 30) idx = 31'($urandom_range(4, 1023));
			else idx = 31'($urandom_range(4, 63));
			send_index(idx);
		end
		wait_drained();
	endtask

	// receiver stalls long while items keep coming; input must back up
	task automatic test_backpressure();
		hold_req++;
		for (int i = 0; i < 4; i++)
			send_index(31'($urandom_range(0, 40)));
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(130);
		repeat (200) @(posedge clk);
		$display("Sent %0d indices (base cases, wide and all-ones indices, random mix)",
			indices_sent);
		$display("Checked %0d sums with random stalls and one long output hold-off",
			sums_checked);
		if (errors == 0 && pending_sums.size() == 0)
			$display("tribonacci_prefix_sum_mod_top_tb passed");
		else
			$display("tribonacci_prefix_sum_mod_top_tb failed");
		$finish;
	end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/tps_pkg.sv
rtl/core/tps_modmul.sv
rtl/core/tribonacci_prefix_sum_mod_top.sv
tb/tribonacci_prefix_sum_mod_top_tb.sv
